>>> rtl/amlu_pkg.sv
// shared types and constants for the automaton membership lookup
`timescale 1ns / 1ps
`default_nettype none
package amlu_pkg;

  // item function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // node header layout
  localparam logic [7:0] COUNT_MASK   = 8'h3F;
  localparam logic [5:0] COUNT_EXT    = 6'd63;
  localparam int         FINAL_BIT    = 7;
  localparam int         COUNT_W      = 9;

  // a transition is a label then a four-byte target; after the label the
  // pointer sits on the target, so a miss skips four more bytes
  localparam logic [2:0] TARGET_SKIP  = 3'd4;

  // target bytes kept; the image address is never wider than this
  localparam int         TARGET_W     = 24;

  // image size as an address width, 64 bytes up to 16 Mbyte
  localparam int         DEF_IMAGE_AW = 16;

  // configuration register map, word index taken from paddr[2]
  localparam logic       REG_ROOT     = 1'b0;

endpackage
`default_nettype wire

>>> rtl/automaton_membership_lookup_unit.sv
// top level: image ram, walk sequencer and configuration port
//
//  channel | handshake                         | payload
//  --------+-----------------------------------+-------------------------------------
//  in      | start, busy (accept: start & !busy)| in_func, in_image_address,
//          |                                   | in_image_byte, in_key_byte, in_key_last
//  out     | out_valid, one cycle per result   | out_found
//  cfg     | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// a write word, an unused function or a byte of a dead key is handled
// without leaving idle; an empty-key query reads the root header. a live
// key byte reads the node header, an extended count byte if the count is
// extended, then the labels in turn (one ram read each) and, on a match,
// the target bytes, plus the target header on the last byte; a miss ends
// the walk. busy is high while a word is being walked.
// reset clears the root, the cursor and the dead flag; the image is not
// cleared. the receiver cannot stall, so out_valid lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module automaton_membership_lookup_unit
  import amlu_pkg::*;
#(
  parameter int IMAGE_AW = DEF_IMAGE_AW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_image_address,
  input  wire logic [7:0]  in_image_byte,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_key_last,
  output logic             out_valid,
  output logic             out_found,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR  = 4'd1;
  localparam logic [3:0] S_EXT  = 4'd2;
  localparam logic [3:0] S_LBL  = 4'd3;
  localparam logic [3:0] S_T0   = 4'd4;
  localparam logic [3:0] S_T1   = 4'd5;
  localparam logic [3:0] S_T2   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_QRY  = 4'd8;

  logic [3:0]          state_r,  state_nxt;
  logic [IMAGE_AW-1:0] addr_r,   addr_nxt;
  logic [COUNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [7:0]          key_r,    key_nxt;
  logic                last_r,   last_nxt;
  logic [15:0]         tgt_r,    tgt_nxt;
  logic [IMAGE_AW-1:0] cursor_r, cursor_nxt;
  logic                dead_r,   dead_nxt;
  logic [15:0]         root_r,   root_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;

  logic                accept;
  logic                cfg_wr;
  logic                miss;
  logic [IMAGE_AW-1:0] base;
  logic [2:0]          off;
  logic [IMAGE_AW-1:0] rd_addr;
  logic [IMAGE_AW-1:0] next_addr;
  logic                ram_we;
  logic [IMAGE_AW-1:0] ram_waddr;
  logic [7:0]          rdata;
  logic [5:0]          hdr_count;
  logic [IMAGE_AW-1:0] root_aw;
  logic [IMAGE_AW-1:0] new_root_aw;
  logic [IMAGE_AW-1:0] target;
  logic [TARGET_W-1:0] target_full;
  logic [IMAGE_AW+15:0] waddr_ext;
  logic [IMAGE_AW+15:0] root_ext;
  logic [IMAGE_AW+15:0] new_root_ext;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROOT);

  // 16-bit offsets reduced to the image size
  assign waddr_ext    = {{IMAGE_AW{1'b0}}, in_image_address};
  assign root_ext     = {{IMAGE_AW{1'b0}}, root_r};
  assign new_root_ext = {{IMAGE_AW{1'b0}}, pwdata[15:0]};
  assign ram_waddr    = waddr_ext[IMAGE_AW-1:0];
  assign root_aw      = root_ext[IMAGE_AW-1:0];
  assign new_root_aw  = new_root_ext[IMAGE_AW-1:0];

  assign hdr_count   = 6'(rdata & COUNT_MASK);
  assign target_full = {rdata, tgt_r};
  assign target      = target_full[IMAGE_AW-1:0];

  amlu_ram #(
    .WIDTH (8),
    .DEPTH (1 << IMAGE_AW)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_image_byte),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  amlu_addr_unit #(
    .IMAGE_AW (IMAGE_AW)
  ) u_addr (
    .base      (base),
    .off       (off),
    .rd_addr   (rd_addr),
    .next_addr (next_addr)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    tgt_nxt       = tgt_r;
    cursor_nxt    = cursor_r;
    dead_nxt      = dead_r;
    root_nxt      = root_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    base          = addr_r;
    off           = 3'd0;
    ram_we        = 1'b0;
    miss          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_WRITE: begin
              ram_we = 1'b1;
            end
            FUNC_KEY: begin
              key_nxt  = in_key_byte;
              last_nxt = in_key_last;
              if (dead_r) begin
                if (in_key_last) begin
                  out_valid_nxt = 1'b1;
                  out_found_nxt = 1'b0;
                  cursor_nxt    = root_aw;
                  dead_nxt      = 1'b0;
                end
              end else begin
                base      = cursor_r;
                addr_nxt  = next_addr;
                state_nxt = S_HDR;
              end
            end
            FUNC_QUERY: begin
              base      = root_aw;
              state_nxt = S_QRY;
            end
            default: begin
            end
          endcase
        end
      end
      S_HDR: begin
        if (hdr_count == COUNT_EXT) begin
          addr_nxt  = next_addr;
          state_nxt = S_EXT;
        end else if (hdr_count == 6'd0) begin
          miss = 1'b1;
        end else begin
          cnt_nxt   = COUNT_W'(hdr_count);
          addr_nxt  = next_addr;
          state_nxt = S_LBL;
        end
      end
      S_EXT: begin
        cnt_nxt   = COUNT_W'(COUNT_EXT) + COUNT_W'(rdata);
        addr_nxt  = next_addr;
        state_nxt = S_LBL;
      end
      S_LBL: begin
        if (rdata == key_r) begin
          addr_nxt  = next_addr;
          state_nxt = S_T0;
        end else if (cnt_r == COUNT_W'(1)) begin
          miss = 1'b1;
        end else begin
          // step over the target bytes to the next label
          cnt_nxt  = cnt_r - COUNT_W'(1);
          off      = TARGET_SKIP;
          addr_nxt = next_addr;
        end
      end
      S_T0: begin
        tgt_nxt[7:0] = rdata;
        addr_nxt     = next_addr;
        state_nxt    = S_T1;
      end
      S_T1: begin
        tgt_nxt[15:8] = rdata;
        state_nxt     = S_T2;
      end
      S_T2: begin
        // upper target byte lies beyond any image size
        cursor_nxt = target;
        if (last_r) begin
          base      = target;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = rdata[FINAL_BIT];
        cursor_nxt    = root_aw;
        dead_nxt      = 1'b0;
        state_nxt     = S_IDLE;
      end
      S_QRY: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = rdata[FINAL_BIT];
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (miss) begin
      state_nxt = S_IDLE;
      if (last_r) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        cursor_nxt    = root_aw;
        dead_nxt      = 1'b0;
      end else begin
        dead_nxt = 1'b1;
      end
    end

    // root write moves the cursor to the new root and clears the dead flag
    if (cfg_wr) begin
      root_nxt   = pwdata[15:0];
      cursor_nxt = new_root_aw;
      dead_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      dead_r      <= 1'b0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      dead_r      <= dead_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    cnt_r       <= cnt_nxt;
    key_r       <= key_nxt;
    last_r      <= last_nxt;
    tgt_r       <= tgt_nxt;
    out_found_r <= out_found_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign prdata    = {16'd0, root_r};
  assign pready    = 1'b1;

endmodule
`default_nettype wire

>>> rtl/amlu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module amlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/amlu_addr_unit.sv
// shared image address adder: read address and the pointer after it
`timescale 1ns / 1ps
`default_nettype none
module amlu_addr_unit
  import amlu_pkg::*;
#(
  parameter int IMAGE_AW = DEF_IMAGE_AW
) (
  input  wire logic [IMAGE_AW-1:0] base,
  input  wire logic [2:0]          off,
  output logic      [IMAGE_AW-1:0] rd_addr,
  output logic      [IMAGE_AW-1:0] next_addr
);

  // sums wrap at the image size by dropping the carry
  assign rd_addr   = base + IMAGE_AW'(off);
  assign next_addr = rd_addr + IMAGE_AW'(1);

endmodule
`default_nettype wire

>>> rtl/amlu_checker.sv
// port-level checks for the lookup unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module amlu_checker
  import amlu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_func,
  input wire logic       in_key_last,
  input wire logic       out_valid
);

  logic acc;
  assign acc = start && !busy;

  // a write word finishes in its own cycle with no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_func == FUNC_WRITE) |=> !busy && !out_valid)
    else $error("write word produced a result or left the unit busy");

  // an empty-key query keeps the unit busy in its query state, then answers
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_func == FUNC_QUERY) |=> busy ##1 out_valid)
    else $error("empty-key query result missing");

  // a key byte that is not the last never gives a result next cycle
  a_mid_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_func == FUNC_KEY) && !in_key_last |=> !out_valid)
    else $error("result on a byte that is not the key's last");

  // every result follows either an accepted word or work in progress
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without a cause");

endmodule

bind automaton_membership_lookup_unit amlu_checker u_amlu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_func     (in_func),
  .in_key_last (in_key_last),
  .out_valid   (out_valid)
);
`default_nettype wire
